### src/linear_key_value_table_top_defines.svh
// Assertion helpers shared by the key to value table.
`ifndef LINEAR_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define KVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define KVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

### src/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

  localparam logic [2:0] OP_SET      = 3'd0;
  localparam logic [2:0] OP_GET      = 3'd1;
  localparam logic [2:0] OP_TAKE     = 3'd2;
  localparam logic [2:0] OP_CONTAINS = 3'd3;
  localparam logic [2:0] OP_RENAME   = 3'd4;
  localparam logic [2:0] OP_FINDVAL  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_TAKE_RD,
    S_TAKE_WR,
    S_DONE
  } kvt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and restart the scan
    logic rd_idx;     // read the entry at the scan index
    logic rd_last;    // read the last entry in use
    logic rec_hit;    // record the matching slot and its result
    logic wr_hit;     // write value (set) or key (rename) at the scan index
    logic adv;        // step the scan index
    logic append;     // write a new entry at the end and grow the count
    logic set_full;   // report a full table
    logic take_move;  // move the last entry into the taken slot
    logic emit;       // load the result into the output register
  } kvt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       scan_end;
    logic       full;
    logic       out_free;
  } kvt_stat_t;

endpackage

`default_nettype wire

### src/kvt_in_if.sv
`default_nettype none

interface kvt_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic signed [31:0] key;
  logic        [31:0] value;
  logic signed [31:0] new_key;

  modport source (output valid, output opcode, output key, output value, output new_key,
                  input ready);
  modport sink (input valid, input opcode, input key, input value, input new_key,
                output ready);
endinterface

`default_nettype wire

### src/kvt_out_if.sv
`default_nettype none

interface kvt_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [31:0] result_value;
  logic signed [31:0] result_key;
  logic        [4:0]  entry_count_out;

  modport source (output valid, output status, output result_value, output result_key,
                  output entry_count_out, input ready);
  modport sink (input valid, input status, input result_value, input result_key,
                input entry_count_out, output ready);
endinterface

`default_nettype wire

### src/kvt_ctrl.sv
`default_nettype none

module kvt_ctrl
  import kvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_opcode,
  output logic            in_ready,
  input  wire kvt_stat_t  stat,
  output kvt_cmd_t        cmd
);

  kvt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // Undefined opcodes skip the scan and report a miss.
          state_nxt = (in_opcode > OP_FINDVAL) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = stat.scan_end ? S_DONE : S_CMP;
      end
      S_CMP: begin
        if (stat.hit) begin
          state_nxt = (stat.op == OP_TAKE) ? S_TAKE_RD : S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_TAKE_RD: state_nxt = S_TAKE_WR;
      S_TAKE_WR: state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // No beat is taken while reset is held.
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
      end
      S_READ: begin
        cmd.rd_idx = !stat.scan_end;
        if (stat.scan_end && stat.op == OP_SET) begin
          cmd.append   = !stat.full;
          cmd.set_full = stat.full;
        end
      end
      S_CMP: begin
        cmd.rec_hit = stat.hit;
        cmd.wr_hit  = stat.hit && (stat.op == OP_SET || stat.op == OP_RENAME);
        cmd.adv     = !stat.hit;
      end
      S_TAKE_RD: cmd.rd_last = 1'b1;
      S_TAKE_WR: cmd.take_move = 1'b1;
      S_DONE:    cmd.emit = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/kvt_dp.sv
`default_nettype none

`include "linear_key_value_table_top_defines.svh"

module kvt_dp
  import kvt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire kvt_cmd_t    cmd,
  output kvt_stat_t        stat,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_value,
  input  wire logic [31:0] in_new_key,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_result_value,
  output logic [31:0]      out_result_key,
  output logic [4:0]       out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [31:0] key_mem [CAPACITY];
  logic [31:0] val_mem [CAPACITY];

  logic [2:0]       req_op_r;
  logic [31:0]      req_key_r, req_val_r, req_nkey_r;
  logic [CNT_W-1:0] idx_r, count_r;
  logic [IDX_W-1:0] slot_r;
  logic [31:0]      key_rd_r, val_rd_r;
  logic [1:0]       res_status_r;
  logic [31:0]      res_val_r, res_key_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_val_r, out_key_r;
  logic [4:0]       out_cnt_r;

  logic [CNT_W-1:0] cnt_dec;
  logic [IDX_W-1:0] rd_addr;
  logic             hit;
  logic             key_we, val_we;
  logic [IDX_W-1:0] key_wa, val_wa;
  logic [31:0]      key_wd, val_wd;

  assign cnt_dec = count_r - CNT_W'(1);
  assign rd_addr = cmd.rd_last ? cnt_dec[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign hit     = (req_op_r == OP_FINDVAL) ? (val_rd_r == req_val_r)
                                            : (key_rd_r == req_key_r);

  assign stat.op       = req_op_r;
  assign stat.hit      = hit;
  assign stat.scan_end = (idx_r == count_r);
  assign stat.full     = (count_r == CNT_W'(CAPACITY));
  assign stat.out_free = !out_valid_r || out_ready;

  // Write port selection; the controller issues at most one kind per cycle.
  always_comb begin
    key_we = 1'b0;
    key_wa = idx_r[IDX_W-1:0];
    key_wd = req_nkey_r;
    val_we = 1'b0;
    val_wa = idx_r[IDX_W-1:0];
    val_wd = req_val_r;
    if (cmd.append) begin
      key_we = 1'b1;
      key_wa = count_r[IDX_W-1:0];
      key_wd = req_key_r;
      val_we = 1'b1;
      val_wa = count_r[IDX_W-1:0];
    end else if (cmd.take_move) begin
      key_we = 1'b1;
      key_wa = slot_r;
      key_wd = key_rd_r;
      val_we = 1'b1;
      val_wa = slot_r;
      val_wd = val_rd_r;
    end else if (cmd.wr_hit) begin
      key_we = (req_op_r == OP_RENAME);
      val_we = (req_op_r == OP_SET);
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (cmd.rd_idx || cmd.rd_last) begin
      key_rd_r <= key_mem[rd_addr];
      val_rd_r <= val_mem[rd_addr];
    end
  end

  // Request and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op_r     <= in_opcode;
      req_key_r    <= in_key;
      req_val_r    <= in_value;
      req_nkey_r   <= in_new_key;
      res_status_r <= ST_MISS;
      res_val_r    <= '0;
      res_key_r    <= (in_opcode == OP_FINDVAL) ? in_key : '0;
    end
    if (cmd.rec_hit) begin
      slot_r       <= idx_r[IDX_W-1:0];
      res_status_r <= ST_OK;
      if (req_op_r == OP_GET || req_op_r == OP_TAKE) begin
        res_val_r <= val_rd_r;
      end
      if (req_op_r == OP_FINDVAL) begin
        res_key_r <= key_rd_r;
      end
    end
    if (cmd.append) begin
      res_status_r <= ST_OK;
    end
    if (cmd.set_full) begin
      res_status_r <= ST_FULL;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_val_r    <= res_val_r;
      out_key_r    <= res_key_r;
      out_cnt_r    <= 5'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.adv) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.take_move) begin
        count_r <= cnt_dec;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_val_r;
  assign out_result_key   = out_key_r;
  assign out_entry_count  = out_cnt_r;

  `KVT_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `KVT_ASSERT(a_append_room, clk, rst_n, !cmd.append || !stat.full, "append into a full table")
  `KVT_ASSERT(a_take_nonempty, clk, rst_n, !cmd.take_move || count_r != '0, "take from empty table")
  `KVT_ASSERT(a_hit_real, clk, rst_n, !cmd.rec_hit || hit, "hit recorded without a match")
  `KVT_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_r, "emitted result not valid")

endmodule

`default_nettype wire

### src/linear_key_value_table_top.sv
// Linear key to value table: a fixed-capacity unsorted array of key/value pairs.
// Requests arrive as beats on in_chan (opcode, key, value, new_key); each request
// produces exactly one result beat on out_chan (status, result_value, result_key,
// entry_count_out). Both channels move a beat when valid and ready are both high.
// One request is worked on at a time. The entries live in two single-port memories
// with registered read data, and a search reads them one slot at a time in storage
// order, alternating a read state and a compare state, stopping at the first match.
// A take then moves the last entry into the freed slot, and an undefined opcode skips
// the search and goes straight to its result. With a ready receiver the next request
// is accepted at the edge of the previous result beat, so the scan of the memories
// sets the spacing of requests. Reset clears the entry count and all control state;
// the stored entries are not cleared, since only slots below the count are ever read.
// A finished result sits in an output register, so a new request is accepted while
// it waits; if the receiver stalls, the next request completes its search and then
// holds until the output register is free.
`default_nettype none

module linear_key_value_table_top
  import kvt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  kvt_in_if.sink    in_chan,
  kvt_out_if.source out_chan
);

  kvt_cmd_t    cmd;
  kvt_stat_t   stat;
  logic        ready;
  logic [31:0] res_key;

  // The controller sequences each request: accept, scan, write back, emit.
  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the memories, the entry count and the output register.
  kvt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_chan.opcode),
    .in_key           (in_chan.key),
    .in_value         (in_chan.value),
    .in_new_key       (in_chan.new_key),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_status       (out_chan.status),
    .out_result_value (out_chan.result_value),
    .out_result_key   (res_key),
    .out_entry_count  (out_chan.entry_count_out)
  );

  assign in_chan.ready       = ready;
  assign out_chan.result_key = signed'(res_key);

endmodule

`default_nettype wire
